### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked
`define LSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked
`define LSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Types, constants and tables for the logistic selectivity curve.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int unsigned WORD_W    = 16;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned T_Q_W     = 15;   // |t| in Q3.12, at most 5.0
    localparam int unsigned M_W       = 31;   // 2^frac in Q30
    localparam int unsigned P_W       = 53;   // 2^y in Q30, y below 22
    localparam int unsigned D_W       = 54;
    localparam int unsigned FRAC_W    = 12;
    localparam int unsigned N_W       = 6;
    localparam int unsigned POW_STEPS = 12;

    // log2(19) in Q20
    localparam logic [23:0] LOG2_19_Q20 = 24'd4454275;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_POINT   = 8'd0,
        REG_SPREAD_TO_95 = 8'd1,
        REG_MAX_LEVEL    = 8'd2,
        REG_MIN_VALUE    = 8'd3
    } lsc_reg_t;

    // What the final stage outputs
    typedef enum logic [1:0] {
        KIND_CURVE = 2'd0,
        KIND_ZERO  = 2'd1,
        KIND_MAX   = 2'd2
    } lsc_kind_t;

    // 2^(2^-(j+1)) in Q30
    function automatic logic [M_W-1:0] pow2_frac_q30(input logic [3:0] j);
        logic [M_W-1:0] c;
        case (j)
            4'd0:    c = 31'd1518500250;
            4'd1:    c = 31'd1276901417;
            4'd2:    c = 31'd1170923762;
            4'd3:    c = 31'd1121280436;
            4'd4:    c = 31'd1097253708;
            4'd5:    c = 31'd1085434106;
            4'd6:    c = 31'd1079572136;
            4'd7:    c = 31'd1076653033;
            4'd8:    c = 31'd1075196443;
            4'd9:    c = 31'd1074468888;
            4'd10:   c = 31'd1074105294;
            4'd11:   c = 31'd1073923544;
            default: c = 31'd1073741824;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/lsc_divider.sv
// ----------------------------------------------------------------------------
// lsc_divider
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Requires num < den * 2^Q_W.
// ----------------------------------------------------------------------------
module lsc_divider #(
    parameter int unsigned DEN_W  = 16,
    parameter int unsigned Q_W    = 15,
    parameter int unsigned SIDE_W = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [DEN_W+Q_W-1:0]   num,
    input  logic [DEN_W-1:0]       den,
    input  logic [SIDE_W-1:0]      side_in,
    output logic                   out_vld,
    output logic [Q_W-1:0]         quo,
    output logic [SIDE_W-1:0]      side_out
);

    // entry 0 is the stage input, entry k+1 the register after step k
    logic              vld_reg  [Q_W+1];
    logic [DEN_W-1:0]  rem_reg  [Q_W+1];
    logic [Q_W-1:0]    low_reg  [Q_W+1];
    logic [Q_W-1:0]    quo_reg  [Q_W+1];
    logic [DEN_W-1:0]  den_reg  [Q_W+1];
    logic [SIDE_W-1:0] side_reg [Q_W+1];

    assign vld_reg[0]  = in_vld;
    assign rem_reg[0]  = num[DEN_W+Q_W-1:Q_W];
    assign low_reg[0]  = num[Q_W-1:0];
    assign quo_reg[0]  = '0;
    assign den_reg[0]  = den;
    assign side_reg[0] = side_in;

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        // trial subtract of the divisor
        always_comb
        begin
            trial    = {rem_reg[k], low_reg[k][Q_W-1]};
            ge       = (trial >= {1'b0, den_reg[k]});
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg[k]}) : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                low_reg[k+1]  <= {low_reg[k][Q_W-2:0], 1'b0};
                quo_reg[k+1]  <= {quo_reg[k][Q_W-2:0], ge};
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_vld  = vld_reg[Q_W];
    assign quo      = quo_reg[Q_W];
    assign side_out = side_reg[Q_W];

endmodule

### hw/rtl/logistic_selectivity_curve.sv
// ----------------------------------------------------------------------------
// logistic_selectivity_curve
// alpha / (1 + 19^((a50 - x) / ato95)) in Q4.12, one word per cycle.
// ----------------------------------------------------------------------------
// Channel  Dir  Word                         Handshake
// s_       in   tdata[15:0] sample_value     s_tvalid / s_tready
// m_       out  tdata[15:0] selectivity      m_tvalid / m_tready
// cfg_     in   cfg_index, cfg_data          cfg_valid / cfg_ready (always 1)
//
// One word per cycle sustained; 49 register stages, among them two
// bit-per-stage dividers (15 and 16 steps) and 12 Q30 multiplies.
// The pipeline moves as one while the output skid slot is empty; a stalled
// output fills the skid and then holds s_tready low until it drains.
// rst_n clears valid bits and restores the register defaults at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module logistic_selectivity_curve
    import lsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [WORD_W-1:0]     s_tdata,     // [15:0] sample_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [WORD_W-1:0]     m_tdata,     // [15:0] selectivity
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data
);

    logic [WORD_W-1:0] half_point_reg, spread_reg, max_level_reg, min_value_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_point_reg <= 16'd0;
            spread_reg     <= 16'd64;
            max_level_reg  <= 16'd4096;
            min_value_reg  <= 16'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HALF_POINT:   half_point_reg <= cfg_data;
                REG_SPREAD_TO_95: spread_reg     <= cfg_data;
                REG_MAX_LEVEL:    max_level_reg  <= cfg_data;
                REG_MIN_VALUE:    min_value_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    logic skid_vld_reg;
    logic en;
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // Stage A: range checks and divider numerator
    logic [WORD_W-1:0] a_spread;
    logic [16:0]       a_diff;
    logic              a_neg;
    logic [WORD_W-1:0] a_mag;
    logic [18:0]       a_five;
    lsc_kind_t         a_kind;
    logic [30:0]       a_num;

    always_comb
    begin
        a_spread = (spread_reg == '0) ? 16'd1 : spread_reg;
        a_diff   = {1'b0, half_point_reg} - {1'b0, s_tdata};
        a_neg    = a_diff[16];
        a_mag    = a_neg ? WORD_W'(17'd0 - a_diff) : a_diff[15:0];
        a_five   = {3'b000, a_spread} + {1'b0, a_spread, 2'b00};
        if (s_tdata < min_value_reg)
            a_kind = KIND_ZERO;
        else if ({3'b000, a_mag} > a_five)
            a_kind = a_neg ? KIND_MAX : KIND_ZERO;
        else
            a_kind = KIND_CURVE;
        a_num    = {3'b000, a_mag, 12'd0} + {16'd0, a_spread[15:1]};
    end

    logic              sa_vld_reg;
    logic [30:0]       sa_num_reg;
    logic [WORD_W-1:0] sa_den_reg;
    logic [2:0]        sa_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sa_vld_reg <= 1'b0;
        else if (en)
            sa_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_num_reg  <= a_num;
            sa_den_reg  <= a_spread;
            sa_side_reg <= {a_neg, a_kind};
        end
    end

    // |t| = round(|d| * 4096 / ato95)
    logic             d1_vld;
    logic [T_Q_W-1:0] d1_quo;
    logic [2:0]       d1_side;

    lsc_divider #(
        .DEN_W  (WORD_W),
        .Q_W    (T_Q_W),
        .SIDE_W (3)
    ) u_t_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (sa_vld_reg),
        .num      (sa_num_reg),
        .den      (sa_den_reg),
        .side_in  (sa_side_reg),
        .out_vld  (d1_vld),
        .quo      (d1_quo),
        .side_out (d1_side)
    );

    // Multiply: t * log2(19)
    logic signed [15:0] mu_t;
    logic               mu_vld_reg;
    logic signed [39:0] mu_prod_reg;
    lsc_kind_t          mu_kind_reg;

    assign mu_t = d1_side[2] ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mu_vld_reg <= 1'b0;
        else if (en)
            mu_vld_reg <= d1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mu_prod_reg <= 40'(mu_t * $signed(LOG2_19_Q20));
            mu_kind_reg <= lsc_kind_t'(d1_side[1:0]);
        end
    end

    // Round to Q.12 and split into integer and fraction; pow stage 0
    logic [39:0] ys_sum;
    assign ys_sum = mu_prod_reg + 40'sd524288;

    logic              pw_vld_reg  [POW_STEPS+1];
    logic [M_W-1:0]    pw_m_reg    [POW_STEPS+1];
    logic [FRAC_W-1:0] pw_f_reg    [POW_STEPS+1];
    logic [N_W-1:0]    pw_n_reg    [POW_STEPS+1];
    lsc_kind_t         pw_kind_reg [POW_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pw_vld_reg[0] <= 1'b0;
        else if (en)
            pw_vld_reg[0] <= mu_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pw_m_reg[0]    <= 31'd1073741824;
            pw_f_reg[0]    <= ys_sum[31:20];
            pw_n_reg[0]    <= ys_sum[37:32];
            pw_kind_reg[0] <= mu_kind_reg;
        end
    end

    // 2^f: one Q30 multiply per fraction bit, top bit first
    for (genvar j = 0; j < POW_STEPS; j++) begin : g_pow
        logic [61:0]    prod;
        logic [M_W-1:0] m_next;

        always_comb
        begin
            prod   = 62'(pw_m_reg[j]) * 62'(pow2_frac_q30(4'(j))) + 62'd536870912;
            m_next = pw_f_reg[j][FRAC_W-1-j] ? prod[60:30] : pw_m_reg[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pw_vld_reg[j+1] <= 1'b0;
            else if (en)
                pw_vld_reg[j+1] <= pw_vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pw_m_reg[j+1]    <= m_next;
                pw_f_reg[j+1]    <= pw_f_reg[j];
                pw_n_reg[j+1]    <= pw_n_reg[j];
                pw_kind_reg[j+1] <= pw_kind_reg[j];
            end
        end
    end

    // Scale by 2^n, rounding on right shifts
    logic [P_W-1:0] sh_m;
    logic [4:0]     sh_s;
    logic [P_W-1:0] sh_p;

    always_comb
    begin
        sh_m = P_W'(pw_m_reg[POW_STEPS]);
        sh_s = 5'(6'd0 - pw_n_reg[POW_STEPS]);
        if (!pw_n_reg[POW_STEPS][N_W-1])
            sh_p = sh_m << pw_n_reg[POW_STEPS][4:0];
        else
            sh_p = (sh_m + (P_W'(1) << (sh_s - 5'd1))) >> sh_s;
    end

    logic           sh_vld_reg;
    logic [P_W-1:0] sh_p_reg;
    lsc_kind_t      sh_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sh_vld_reg <= 1'b0;
        else if (en)
            sh_vld_reg <= pw_vld_reg[POW_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_p_reg    <= sh_p;
            sh_kind_reg <= pw_kind_reg[POW_STEPS];
        end
    end

    // Denominator 1 + 2^y and rounded numerator alpha + D/2
    logic                dn_vld_reg;
    logic [D_W-1:0]      dn_den_reg;
    logic [D_W+15:0]     dn_num_reg;
    lsc_kind_t           dn_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dn_vld_reg <= 1'b0;
        else if (en)
            dn_vld_reg <= sh_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_den_reg  <= (D_W'(1) << 30) + D_W'(sh_p_reg);
            dn_num_reg  <= {24'd0, max_level_reg, 30'd0} + (70'(1) << 29)
                           + 70'(sh_p_reg >> 1);
            dn_kind_reg <= sh_kind_reg;
        end
    end

    // alpha / (1 + 2^y)
    logic              d2_vld;
    logic [WORD_W-1:0] d2_quo;
    logic [1:0]        d2_side;

    lsc_divider #(
        .DEN_W  (D_W),
        .Q_W    (WORD_W),
        .SIDE_W (2)
    ) u_sel_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (dn_vld_reg),
        .num      (dn_num_reg),
        .den      (dn_den_reg),
        .side_in  (dn_kind_reg),
        .out_vld  (d2_vld),
        .quo      (d2_quo),
        .side_out (d2_side)
    );

    // Result select
    logic [WORD_W-1:0] res;
    logic              push;

    always_comb
    begin
        case (lsc_kind_t'(d2_side))
            KIND_ZERO: res = '0;
            KIND_MAX:  res = max_level_reg;
            default:   res = d2_quo;
        endcase
        push = en && d2_vld;
    end

    // Output register with one skid slot
    logic              out_vld_reg;
    logic [WORD_W-1:0] out_data_reg, skid_data_reg;
    logic              out_free;
    assign out_free = !out_vld_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg  <= skid_vld_reg || push;
            skid_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_data_reg <= skid_vld_reg ? skid_data_reg : res;
        else if (push)
            skid_data_reg <= res;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    `LSC_ASSERT_IMP(a_skid_has_out, clk, rst_n, skid_vld_reg, out_vld_reg,
        "skid word held with output register empty")
    `LSC_ASSERT_IMP(a_skid_blocks_in, clk, rst_n, skid_vld_reg, !s_tready && !push,
        "pipeline moved while skid slot was full")
    `LSC_ASSERT_NEXT(a_skid_on_stall, clk, rst_n, !skid_vld_reg && !(m_tvalid && !m_tready),
        !skid_vld_reg, "skid filled without an output stall")
    `LSC_ASSERT_IMP(a_below_max, clk, rst_n, m_tvalid, m_tdata <= max_level_reg,
        "selectivity above maximum level")

endmodule

### dv/logistic_selectivity_curve_tb.sv
// ----------------------------------------------------------------------------
// logistic_selectivity_curve_tb
// Self-checking bench: a queue-fed driver pushes sample words through the
// curve, a monitor compares each selectivity word with a local predictor,
// and register settings are changed between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module logistic_selectivity_curve_tb;
    import lsc_pkg::*;

    localparam int unsigned PIPE_LAT  = 60;
    localparam int unsigned STALL_MAX = 200000;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [WORD_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [WORD_W-1:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0] cfg_data;

    // Predictor copy of the registers
    logic [15:0] a50_q;
    logic [15:0] ato95_q;
    logic [15:0] alpha_q;
    logic [15:0] beta_q;

    logic [15:0] sample_q[$];
    logic [15:0] selectivity_q[$];
    int unsigned n_errors;
    int unsigned idle_cycles;
    bit hold_rx;
    bit long_hold_req;
    bit long_hold_done;

    logistic_selectivity_curve u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Q30 factors for 2^(2^-(k+1))
    function automatic longint unsigned pow2_step(input int k);
        longint unsigned tab[12] = '{64'd1518500250, 64'd1276901417, 64'd1170923762,
            64'd1121280436, 64'd1097253708, 64'd1085434106, 64'd1079572136,
            64'd1076653033, 64'd1075196443, 64'd1074468888, 64'd1074105294,
            64'd1073923544};
        return tab[k];
    endfunction

    // Expected selectivity for one sample under the current registers
    function automatic logic [15:0] predict_selectivity(input logic [15:0] x);
        longint a, d, t, p, y, n;
        longint unsigned mag, q, u, m, pw, den, num, r;
        int unsigned f;
        int s;
        if (x < beta_q)
            return 16'd0;
        a = (ato95_q == 0) ? 1 : longint'(ato95_q);
        d = longint'(a50_q) - longint'(x);
        if (d > 5 * a)
            return 16'd0;
        if (d < -5 * a)
            return alpha_q;
        mag = longint'(d < 0 ? -d : d) << 12;
        q = (mag + a / 2) / a;
        t = (d < 0) ? -longint'(q) : longint'(q);
        p = t * 64'sd4454275;
        u = ($unsigned(p + (64'sd1 << 40)) + (64'd1 << 19)) >> 20;
        y = longint'(u) - (64'sd1 << 20);
        u = $unsigned(y + (64'sd32 << 12));
        n = longint'(u >> 12) - 32;
        f = 32'(u & 64'd4095);
        m = 64'd1 << 30;
        for (int k = 0; k < 12; k++)
            if ((f >> (11 - k)) & 1)
                m = (m * pow2_step(k) + (64'd1 << 29)) >> 30;
        if (n >= 0)
            pw = m << n;
        else
        begin
            s = int'(-n);
            pw = (m + (64'd1 << (s - 1))) >> s;
        end
        den = (64'd1 << 30) + pw;
        num = 64'(alpha_q) << 30;
        r = (num + den / 2) / den;
        if (r > 65535)
            r = 65535;
        return r[15:0];
    endfunction

    // Register write, predictor updated at the same edge
    task automatic write_reg(input lsc_reg_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_HALF_POINT:   a50_q   = val;
            REG_SPREAD_TO_95: ato95_q = val;
            REG_MAX_LEVEL:    alpha_q = val;
            REG_MIN_VALUE:    beta_q  = val;
            default: ;
        endcase
    endtask

    task automatic set_curve(input logic [15:0] a50, input logic [15:0] ato,
                             input logic [15:0] alpha, input logic [15:0] beta);
        write_reg(REG_HALF_POINT, a50);
        write_reg(REG_SPREAD_TO_95, ato);
        write_reg(REG_MAX_LEVEL, alpha);
        write_reg(REG_MIN_VALUE, beta);
    endtask

    // Wait for the pipe to drain completely
    task automatic drain();
        wait (sample_q.size() == 0 && selectivity_q.size() == 0);
        repeat (PIPE_LAT) @(posedge clk);
        wait (sample_q.size() == 0 && selectivity_q.size() == 0);
    endtask

    // Samples mostly around the transition region, some anywhere
    function automatic logic [15:0] pick_sample();
        int span;
        int v;
        span = 6 * ((ato95_q == 0) ? 1 : ato95_q);
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 65535));
        v = int'(a50_q) + $urandom_range(0, 2 * span) - span;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // Driver: one word per accept, random gaps
    int unsigned tx_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_gap   <= 0;
        end
        else
        begin
            // the accepted word leaves the queue here, so the front is the next one
            if (s_tvalid && s_tready)
                void'(sample_q.pop_front());
            if (s_tvalid && !s_tready)
                ;
            else if (tx_gap != 0)
            begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end
            else if (sample_q.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= sample_q[0];
                if ($urandom_range(0, 3) == 0)
                    tx_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                                                          : $urandom_range(1, 2);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Expectation is formed at accept time with the registers then in force
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            selectivity_q.push_back(predict_selectivity(s_tdata));
    end

    // Receiver back-pressure, including one long hold-off
    int unsigned rx_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
            hold_rx  <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done && !hold_rx)
        begin
            hold_rx  <= 1'b1;
            rx_gap   <= 400;
            m_tready <= 1'b0;
        end
        else if (rx_gap != 0)
        begin
            rx_gap   <= rx_gap - 1;
            m_tready <= 1'b0;
            if (rx_gap == 1 && hold_rx)
                long_hold_done <= 1'b1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            rx_gap   <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40)
                                                    : $urandom_range(0, 2);
        end
        else
            m_tready <= ($urandom_range(0, 7) != 0);
    end

    // Monitor: compare each output word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (selectivity_q.size() == 0)
            begin
                $error("selectivity: unexpected word 0x%h", m_tdata);
                n_errors++;
            end
            else if (m_tdata !== selectivity_q[0])
            begin
                $error("selectivity: expected 0x%h, got 0x%h", selectivity_q[0], m_tdata);
                n_errors++;
                void'(selectivity_q.pop_front());
            end
            else
                void'(selectivity_q.pop_front());
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX)
        begin
            $display("FAIL logistic_selectivity_curve");
            $finish;
        end
    end

    // Stimulus sequencing
    initial
    begin
        logic [15:0] edge_vals[8];
        n_errors       = 0;
        idle_cycles    = 0;
        long_hold_req  = 1'b0;
        long_hold_done = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        a50_q          = 16'd0;
        ato95_q        = 16'd64;
        alpha_q        = 16'd4096;
        beta_q         = 16'd0;
        rst_n          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset curve, field extremes and special cases
        edge_vals = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001,
                      16'd64, 16'd320, 16'd321};
        foreach (edge_vals[i])
            sample_q.push_back(edge_vals[i]);
        drain();
        // half point, below minimum, far above and below, zero spread
        set_curve(16'd1600, 16'd0, 16'hFFFF, 16'd1000);
        foreach (edge_vals[i])
            sample_q.push_back(edge_vals[i]);
        sample_q.push_back(16'd999);
        sample_q.push_back(16'd1000);
        sample_q.push_back(16'd1595);
        sample_q.push_back(16'd1600);
        sample_q.push_back(16'd1605);
        drain();
        set_curve(16'd32000, 16'd640, 16'd4096, 16'd0);
        for (int k = -4; k <= 4; k++)
            sample_q.push_back(16'(32000 + k * 800));
        drain();

        // Random phases with varied settings, extremes included
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0: set_curve(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: set_curve(16'd0, 16'd1, 16'd0, 16'd0);
                2: set_curve(16'd40000, 16'd1, 16'hFFFF, 16'd0);
                default: set_curve(16'($urandom_range(0, 65535)),
                                   16'(($urandom_range(0, 1) ? $urandom_range(1, 2000)
                                                             : $urandom_range(0, 65535))),
                                   16'($urandom_range(0, 65535)),
                                   16'((($urandom_range(0, 2) == 0)
                                        ? $urandom_range(0, 65535)
                                        : $urandom_range(0, 500))));
            endcase
            for (int i = 0; i < 150; i++)
                sample_q.push_back(pick_sample());
            if (ph == 4)
                long_hold_req = 1'b1;
            if (ph == 7)
            begin
                // Sender pause until everything has come back
                drain();
                for (int i = 0; i < 50; i++)
                    sample_q.push_back(pick_sample());
            end
            drain();
        end

        if (n_errors == 0)
            $display("PASS logistic_selectivity_curve");
        else
            $display("FAIL logistic_selectivity_curve");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/lsc_pkg.sv
hw/rtl/lsc_divider.sv
hw/rtl/logistic_selectivity_curve.sv
dv/logistic_selectivity_curve_tb.sv
